@@ rtl/agsq_pkg.sv @@
// Package for the sorted agenda queue: operation and status codes, cell control
// group and default sizes. Used by agsq_cell and the top level; has no
// dependencies of its own.
package agsq_pkg;

	localparam int DEF_CAPACITY      = 64;
	localparam int DEF_PRIORITY_BITS = 16;
	localparam int DEF_ID_BITS       = 16;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_POP    = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NOT_FOUND = 3'd1,
		ST_DUPLICATE = 3'd2,
		ST_FULL      = 3'd3,
		ST_POP_EMPTY = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		MODE_HOLD,
		MODE_INSERT,
		MODE_REMOVE,
		MODE_POP
	} cell_mode_t;

	// Broadcast from the top level to every cell.
	typedef struct packed {
		logic       capture;  // latch compare flags against the incoming item
		cell_mode_t mode;     // how the row moves on this edge
	} cell_ctl_t;

endpackage

@@ rtl/agsq_cell.sv @@
// One slot of the sorted agenda row: holds an entry, compares it with the
// incoming item and takes its own, its neighbor's or the new entry.
// Depends on agsq_pkg.
module agsq_cell import agsq_pkg::*; #(
	parameter int CAPACITY      = DEF_CAPACITY,
	parameter int PRIORITY_BITS = DEF_PRIORITY_BITS,
	parameter int ID_BITS       = DEF_ID_BITS,
	parameter int INDEX         = 0,
	localparam int EW           = PRIORITY_BITS + 1 + 2 * ID_BITS,
	localparam int CW           = $clog2(CAPACITY + 1)
) (
	input  logic          clk,
	input  cell_ctl_t     ctl,
	input  logic [CW-1:0] count,
	input  logic [EW-1:0] in_entry,
	input  logic [EW-1:0] req_entry,
	input  logic          prev_before,
	input  logic [EW-1:0] prev_entry,
	input  logic [EW-1:0] next_entry,
	output logic [EW-1:0] entry,
	output logic          before_q,
	output logic          same_q
);

	logic [EW-1:0] entry_q;
	logic          valid;
	logic          ahead;

	// Map the entry to a key whose unsigned order is service order.
	function automatic logic [EW-1:0] order_key(input logic [EW-1:0] x);
		order_key = {~x[EW-1], x[EW-2:2*ID_BITS], ~x[2*ID_BITS-1:0]};
	endfunction

	assign valid  = count > CW'(INDEX);
	assign ahead  = valid && (order_key(entry_q) > order_key(in_entry));
	assign entry  = entry_q;

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			before_q <= ahead;
			same_q   <= valid && (entry_q == in_entry);
		end
		case (ctl.mode)
			MODE_INSERT: begin
				if (!before_q) begin
					entry_q <= prev_before ? req_entry : prev_entry;
				end
			end
			MODE_REMOVE: begin
				if (!before_q) begin
					entry_q <= next_entry;
				end
			end
			MODE_POP: begin
				entry_q <= next_entry;
			end
			default: begin
			end
		endcase
	end

endmodule

@@ rtl/agenda_sorted_priority_queue_core.sv @@
// Sorted agenda queue, top level: a row of agsq_cell slots kept in service
// order, plus request, status and result handshake registers.
// Depends on agsq_pkg and agsq_cell.
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+----------------------------------------
//   in       | into core | in_valid / in_stall | operation, priority_req, is_retract,
//            |           |                     | token_id, production_id
//   out      | from core | out_valid/out_stall | status, front_*, is_empty, entry_count
//
// Each item goes through an accept edge and an apply edge: on the accept edge every
// cell compares its entry with the item and latches "serves before" and "same"
// flags; on the apply edge the flags are reduced to found/full and the whole row
// shifts or holds at once. A new item is held off while one is pending. The apply
// edge waits while a previous result is stalled.
// Reset clears the count and the handshake state; cell contents are left as they
// are, since only the first entry_count slots are ever read.
module agenda_sorted_priority_queue_core import agsq_pkg::*; #(
	parameter int CAPACITY      = DEF_CAPACITY,
	parameter int PRIORITY_BITS = DEF_PRIORITY_BITS,
	parameter int ID_BITS       = DEF_ID_BITS,
	localparam int EW           = PRIORITY_BITS + 1 + 2 * ID_BITS,
	localparam int CW           = $clog2(CAPACITY + 1)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      operation,
	input  logic signed [PRIORITY_BITS-1:0] priority_req,
	input  logic                            is_retract,
	input  logic [ID_BITS-1:0]              token_id,
	input  logic [ID_BITS-1:0]              production_id,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [2:0]                      status,
	output logic                            front_valid,
	output logic signed [PRIORITY_BITS-1:0] front_priority,
	output logic                            front_is_retract,
	output logic [ID_BITS-1:0]              front_token_id,
	output logic [ID_BITS-1:0]              front_production_id,
	output logic                            is_empty,
	output logic [CW-1:0]                   entry_count
);

	// Request holding registers
	logic          pend_q;
	logic [1:0]    op_q;
	logic [EW-1:0] req_q;

	// Result registers
	logic          out_valid_q;
	status_t       status_q;
	logic [CW-1:0] count_q;

	logic [EW-1:0] in_entry;
	logic          accept;
	logic          apply;
	logic          found;
	logic          full;
	logic          empty;
	cell_ctl_t     ctl;
	status_t       status_nxt;
	logic [CW-1:0] count_nxt;

	logic [EW-1:0]       cell_entry [CAPACITY];
	logic [CAPACITY-1:0] before_vec;
	logic [CAPACITY-1:0] same_vec;

	assign in_entry = {priority_req, is_retract, token_id, production_id};
	assign in_stall = pend_q;
	assign accept   = in_valid && !pend_q;
	// Apply the pending item once the result slot is free or being drained.
	assign apply    = pend_q && (!out_valid_q || !out_stall);

	// At most one cell can match, since the set holds no duplicates.
	assign found = |same_vec;
	assign full  = count_q == CW'(CAPACITY);
	assign empty = count_q == '0;

	always_comb begin
		ctl.capture = accept;
		ctl.mode    = MODE_HOLD;
		status_nxt  = ST_OK;
		count_nxt   = count_q;
		case (op_q)
			OP_INSERT: begin
				if (found) begin
					status_nxt = ST_DUPLICATE;
				end else if (full) begin
					status_nxt = ST_FULL;
				end else begin
					ctl.mode  = MODE_INSERT;
					count_nxt = count_q + 1'b1;
				end
			end
			OP_REMOVE: begin
				if (!found) begin
					status_nxt = ST_NOT_FOUND;
				end else begin
					ctl.mode  = MODE_REMOVE;
					count_nxt = count_q - 1'b1;
				end
			end
			OP_POP: begin
				if (empty) begin
					status_nxt = ST_POP_EMPTY;
				end else begin
					ctl.mode  = MODE_POP;
					count_nxt = count_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
		// Drop the row update unless this is the apply edge.
		if (!apply) begin
			ctl.mode = MODE_HOLD;
		end
	end

	// Cell row: each slot hands its entry and compare flag to its neighbors.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic          prev_before;
		logic [EW-1:0] prev_entry;
		logic [EW-1:0] next_entry;

		if (i == 0) begin : g_head
			assign prev_before = 1'b1;
			assign prev_entry  = req_q;
		end else begin : g_body
			assign prev_before = before_vec[i-1];
			assign prev_entry  = cell_entry[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign next_entry = '0;
		end else begin : g_link
			assign next_entry = cell_entry[i+1];
		end

		agsq_cell #(
			.CAPACITY      (CAPACITY),
			.PRIORITY_BITS (PRIORITY_BITS),
			.ID_BITS       (ID_BITS),
			.INDEX         (i)
		) u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.count       (count_q),
			.in_entry    (in_entry),
			.req_entry   (req_q),
			.prev_before (prev_before),
			.prev_entry  (prev_entry),
			.next_entry  (next_entry),
			.entry       (cell_entry[i]),
			.before_q    (before_vec[i]),
			.same_q      (same_vec[i])
		);
	end

	// Hold the request payload for the apply edge.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= operation;
			req_q <= in_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
			status_q    <= ST_OK;
			count_q     <= '0;
		end else begin
			if (accept) begin
				pend_q <= 1'b1;
			end else if (apply) begin
				pend_q <= 1'b0;
			end
			if (apply) begin
				out_valid_q <= 1'b1;
				status_q    <= status_nxt;
				count_q     <= count_nxt;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Front fields follow slot zero; the row only moves on an apply edge,
	// which never happens while a result is stalled.
	assign out_valid           = out_valid_q;
	assign status              = status_q;
	assign front_valid         = !empty;
	assign front_priority      = empty ? '0 : cell_entry[0][EW-1 -: PRIORITY_BITS];
	assign front_is_retract    = !empty && cell_entry[0][2*ID_BITS];
	assign front_token_id      = empty ? '0 : cell_entry[0][2*ID_BITS-1 -: ID_BITS];
	assign front_production_id = empty ? '0 : cell_entry[0][ID_BITS-1:0];
	assign is_empty            = empty;
	assign entry_count         = count_q;

endmodule

@@ dv/agenda_sorted_priority_queue_core_tb.sv @@
// Self-checking testbench for agenda_sorted_priority_queue_core: random and directed
// insert/remove/pop items against a queue-based model of the sorted agenda.
// Depends on agsq_pkg and the core RTL only.
`timescale 1ns / 100ps

module agenda_sorted_priority_queue_core_tb;
	import agsq_pkg::*;

	localparam int CAP = DEF_CAPACITY;
	localparam int PB  = DEF_PRIORITY_BITS;
	localparam int IB  = DEF_ID_BITS;
	localparam int CW  = $clog2(CAP + 1);

	// Code three carries no operation; the block just reports its state.
	localparam logic [1:0] OP_NOP = 2'd3;

	// Roughly this many items in total, directed part included.
	localparam int ITEM_TARGET = 1150;
	// Quiet cycles after the last result before the verdict.
	localparam int DRAIN_CYCLES = 20;
	// Keep the log short on a badly broken block; counting goes on.
	localparam int PRINT_LIMIT = 200;

	typedef struct packed {
		logic [PB-1:0] prio;
		logic          retract;
		logic [IB-1:0] tok;
		logic [IB-1:0] prod;
	} agenda_entry_t;

	typedef struct {
		logic [2:0]    status;
		logic          front_valid;
		agenda_entry_t front;
		logic          is_empty;
		logic [CW-1:0] count;
	} agenda_result_t;

	// Mirror of the agenda plus the results still owed by the block.
	class agenda_scoreboard;
		agenda_entry_t  held_entries[$];      // kept in service order
		agenda_result_t expected_results[$];  // oldest first
		int             errors;

		function new();
			errors = 0;
		endfunction

		// True when a is served before b.
		static function bit serves_before(agenda_entry_t a, agenda_entry_t b);
			if (a.prio != b.prio)
				return $signed(a.prio) > $signed(b.prio);
			if (a.retract != b.retract)
				return a.retract;
			if (a.tok != b.tok)
				return a.tok < b.tok;
			return a.prod < b.prod;
		endfunction

		// Apply one accepted item to the mirror and queue the result it owes.
		function void note_item(logic [1:0] op, agenda_entry_t e);
			int             pos;
			bit             found;
			agenda_result_t r;
			pos = 0;
			while (pos < held_entries.size() && serves_before(held_entries[pos], e))
				pos++;
			found = (pos < held_entries.size()) && (held_entries[pos] == e);
			r.status = ST_OK;
			case (op)
				OP_INSERT: begin
					// duplicate wins over full
					if (found)
						r.status = ST_DUPLICATE;
					else if (held_entries.size() >= CAP)
						r.status = ST_FULL;
					else
						held_entries.insert(pos, e);
				end
				OP_REMOVE: begin
					if (!found)
						r.status = ST_NOT_FOUND;
					else
						held_entries.delete(pos);
				end
				OP_POP: begin
					if (held_entries.size() == 0)
						r.status = ST_POP_EMPTY;
					else
						held_entries.delete(0);
				end
				default: ;
			endcase
			r.front_valid = held_entries.size() != 0;
			r.front       = r.front_valid ? held_entries[0] : '0;
			r.is_empty    = held_entries.size() == 0;
			r.count       = CW'(held_entries.size());
			expected_results.push_back(r);
		endfunction

		task report_mismatch(string what, logic [63:0] want, logic [63:0] got);
			errors++;
			if (errors <= PRINT_LIMIT)
				$display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
		endtask

		// Compare one result from the block with the oldest expectation.
		task check_result(agenda_result_t got);
			agenda_result_t want;
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result", 64'd0, 64'd1);
				return;
			end
			want = expected_results[0];
			expected_results.delete(0);
			if (got.status != want.status)
				report_mismatch("status", want.status, got.status);
			if (got.front_valid != want.front_valid)
				report_mismatch("front_valid", want.front_valid, got.front_valid);
			if (got.front.prio != want.front.prio)
				report_mismatch("front_priority", want.front.prio, got.front.prio);
			if (got.front.retract != want.front.retract)
				report_mismatch("front_is_retract", want.front.retract, got.front.retract);
			if (got.front.tok != want.front.tok)
				report_mismatch("front_token_id", want.front.tok, got.front.tok);
			if (got.front.prod != want.front.prod)
				report_mismatch("front_production_id", want.front.prod, got.front.prod);
			if (got.is_empty != want.is_empty)
				report_mismatch("is_empty", want.is_empty, got.is_empty);
			if (got.count != want.count)
				report_mismatch("entry_count", want.count, got.count);
		endtask
	endclass

	// Clock, reset and every block input start at known values.
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                 in_valid      = 1'b0;
	logic                 in_stall;
	logic [1:0]           operation     = OP_NOP;
	logic signed [PB-1:0] priority_req  = '0;
	logic                 is_retract    = 1'b0;
	logic [IB-1:0]        token_id      = '0;
	logic [IB-1:0]        production_id = '0;

	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [2:0]           status;
	logic                 front_valid;
	logic signed [PB-1:0] front_priority;
	logic                 front_is_retract;
	logic [IB-1:0]        front_token_id;
	logic [IB-1:0]        front_production_id;
	logic                 is_empty;
	logic [CW-1:0]        entry_count;

	// While set, neither side idles: back-to-back items and no output stall.
	bit steady = 1'b0;
	int items_sent = 0;

	agenda_scoreboard sb = new();

	always #1 clk = ~clk;

	agenda_sorted_priority_queue_core #(
		.CAPACITY      (CAP),
		.PRIORITY_BITS (PB),
		.ID_BITS       (IB)
	) i_dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.operation           (operation),
		.priority_req        (priority_req),
		.is_retract          (is_retract),
		.token_id            (token_id),
		.production_id       (production_id),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.status              (status),
		.front_valid         (front_valid),
		.front_priority      (front_priority),
		.front_is_retract    (front_is_retract),
		.front_token_id      (front_token_id),
		.front_production_id (front_production_id),
		.is_empty            (is_empty),
		.entry_count         (entry_count)
	);

	// Stall the result side about 13 times in a hundred, never during a steady stretch.
	always @(posedge clk) begin
		out_stall <= !steady && ($urandom_range(0, 99) < 13);
	end

	// Sample at the edge: the values seen here are the ones the handshake used.
	always @(posedge clk) begin
		agenda_result_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.status      = status;
			got.front_valid = front_valid;
			got.front.prio    = front_priority;
			got.front.retract = front_is_retract;
			got.front.tok     = front_token_id;
			got.front.prod    = front_production_id;
			got.is_empty    = is_empty;
			got.count       = entry_count;
			sb.check_result(got);
		end
	end

	// Hard stop well past the slowest legal run.
	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// Build an entry. Mostly draw from a narrow pool so that duplicates,
	// exact removes and equal-priority tie breaks come up often; sometimes
	// take full-range fields or the extremes of each field.
	function automatic agenda_entry_t make_entry();
		agenda_entry_t e;
		int unsigned   kind;
		kind = $urandom_range(0, 9);
		if (kind < 7) begin
			e.prio    = PB'(int'($urandom_range(0, 4)) - 2);
			e.retract = 1'($urandom_range(0, 1));
			e.tok     = IB'($urandom_range(0, 3));
			e.prod    = IB'($urandom_range(0, 3));
		end else if (kind < 9) begin
			e.prio    = PB'($urandom);
			e.retract = 1'($urandom_range(0, 1));
			e.tok     = IB'($urandom);
			e.prod    = IB'($urandom);
		end else begin
			e.prio    = $urandom_range(0, 1) ? {1'b0, {(PB-1){1'b1}}} : {1'b1, {(PB-1){1'b0}}};
			e.retract = 1'($urandom_range(0, 1));
			e.tok     = $urandom_range(0, 1) ? '1 : '0;
			e.prod    = $urandom_range(0, 1) ? '1 : '0;
		end
		return e;
	endfunction

	// Pick an entry the agenda holds right now, or a fresh one when it is empty.
	function automatic agenda_entry_t pick_held();
		if (sb.held_entries.size() == 0)
			return make_entry();
		return sb.held_entries[$urandom_range(0, sb.held_entries.size() - 1)];
	endfunction

	function automatic agenda_entry_t fields(int p, bit r, int t, int d);
		agenda_entry_t e;
		e.prio    = PB'(p);
		e.retract = r;
		e.tok     = IB'(t);
		e.prod    = IB'(d);
		return e;
	endfunction

	// Offer one item, with a random idle gap first, and return at its accept edge.
	// Valid stays high afterwards so the next item can follow back to back.
	task automatic send_item(input logic [1:0] op, input agenda_entry_t e);
		while (!steady && $urandom_range(0, 99) < 13) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		operation     <= op;
		priority_req  <= e.prio;
		is_retract    <= e.retract;
		token_id      <= e.tok;
		production_id <= e.prod;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_item(op, e);
		items_sent++;
	endtask

	// Mixed traffic around whatever the agenda holds.
	task automatic churn_round(input int n);
		int unsigned w;
		repeat (n) begin
			w = $urandom_range(0, 99);
			if (w < 45)
				send_item(OP_INSERT, make_entry());
			else if (w < 65)
				send_item(OP_REMOVE, pick_held());
			else if (w < 75)
				send_item(OP_REMOVE, make_entry());
			else if (w < 95)
				send_item(OP_POP, make_entry());
			else
				send_item(OP_NOP, make_entry());
		end
	endtask

	// Insert until full, then push on: dropped inserts and duplicates on a full set.
	task automatic fill_round();
		while (sb.held_entries.size() < CAP)
			send_item(OP_INSERT, make_entry());
		repeat (4) begin
			if ($urandom_range(0, 1))
				send_item(OP_INSERT, pick_held());
			else
				send_item(OP_INSERT, make_entry());
		end
	endtask

	// Empty the agenda, mostly by pops, then poke the empty set.
	task automatic drain_round();
		while (sb.held_entries.size() != 0) begin
			if ($urandom_range(0, 99) < 80)
				send_item(OP_POP, make_entry());
			else
				send_item(OP_REMOVE, pick_held());
		end
		send_item(OP_POP, make_entry());
		send_item(OP_REMOVE, make_entry());
		send_item(OP_POP, make_entry());
	endtask

	initial begin
		int round;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty-set cases first.
		send_item(OP_POP,    fields(0, 1'b0, 0, 0));
		send_item(OP_REMOVE, fields(7, 1'b1, 3, 3));
		send_item(OP_NOP,    fields(-1, 1'b1, 16'hffff, 16'hffff));
		// Field extremes: highest and lowest priority, all-ones and all-zero ids.
		send_item(OP_INSERT, fields(-32768, 1'b1, 0, 0));
		send_item(OP_INSERT, fields(32767, 1'b0, 16'hffff, 16'hffff));
		send_item(OP_INSERT, fields(32767, 1'b1, 16'hffff, 0));
		// Ties at equal priority: retract first, then token id, then production id.
		send_item(OP_INSERT, fields(0, 1'b0, 5, 9));
		send_item(OP_INSERT, fields(0, 1'b1, 5, 9));
		send_item(OP_INSERT, fields(0, 1'b1, 4, 9));
		send_item(OP_INSERT, fields(0, 1'b1, 4, 8));
		// Duplicate insert leaves the set alone.
		send_item(OP_INSERT, fields(0, 1'b1, 4, 8));
		// Remove of an absent neighbor, then of an exact match.
		send_item(OP_REMOVE, fields(0, 1'b1, 4, 7));
		send_item(OP_REMOVE, fields(0, 1'b1, 4, 9));
		send_item(OP_NOP,    fields(0, 1'b0, 0, 0));
		send_item(OP_POP,    fields(0, 1'b0, 0, 0));
		send_item(OP_POP,    fields(0, 1'b0, 0, 0));
		send_item(OP_REMOVE, fields(-32768, 1'b1, 0, 0));

		// Random part: churn, fill to full, churn, drain to empty, churn, repeat.
		// A stretch in the middle runs with no idling on either side.
		round = 0;
		while (items_sent < ITEM_TARGET) begin
			steady <= (items_sent >= 400) && (items_sent < 650);
			case (round % 5)
				1:       fill_round();
				3:       drain_round();
				default: churn_round(40);
			endcase
			round++;
		end

		// Stop offering, let the last results come out, then wait out the pipeline.
		in_valid <= 1'b0;
		while (sb.expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ agenda_sorted_priority_queue_core.f @@
rtl/agsq_pkg.sv
rtl/agsq_cell.sv
rtl/agenda_sorted_priority_queue_core.sv
dv/agenda_sorted_priority_queue_core_tb.sv
